@@ design/gme_pkg.sv @@
package gme_pkg;

	// sizes
	localparam int MAX_SAMPLES = 8;
	localparam int MAX_DIM     = 64;
	localparam int STORE_DEPTH = MAX_SAMPLES * MAX_DIM;

	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 2 * ELEM_W;
	localparam int DOT_W   = 38;
	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int IDX_W   = $clog2(MAX_SAMPLES);
	localparam int K_W     = $clog2(MAX_DIM);
	localparam int CNT_W   = 4;
	localparam int DIM_W   = 7;
	localparam int CFG_W   = 7;
	localparam int CFGI_W  = 1;

	// register indexes
	localparam logic [CFGI_W-1:0] REG_SAMPLE_COUNT = 1'd0;
	localparam logic [CFGI_W-1:0] REG_DIMENSION    = 1'd1;

	// controller to datapath commands
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_issue;
		logic              rd_last;
		logic              acc_clr;
		logic              out_load;
		logic              out_last;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [K_W-1:0]    k;
		logic [DIM_W-1:0]  dim;
	} gme_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic acc_done;
	} gme_status_t;

endpackage

@@ design/gram_matrix_engine.sv @@
// loading: one element word per cycle while in the load state, the final element starts the computation
// each gram entry takes one mac per column through the two-port store
// each result passes the read registers, the multiplier and the accumulator before the output register
// a held output word stalls the next result; loading resumes once the final result is registered
// reset: sample_count 8, dimension 64, load position 0; matrix store is not cleared
module gram_matrix_engine
	import gme_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFGI_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ELEM_W-1:0] element,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         row_index,
	output logic [IDX_W-1:0]         col_index,
	output logic signed [DOT_W-1:0]  dot_value,
	output logic                     last
);

	gme_cmd_t    cmd;
	gme_status_t status;

	// sequencing and configuration
	gme_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// store, multiply-accumulate and output register
	gme_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.element   (element),
		.status    (status),
		.row_index (row_index),
		.col_index (col_index),
		.dot_value (dot_value),
		.last      (last)
	);

endmodule

@@ design/gme_datapath.sv @@
module gme_datapath
	import gme_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  gme_cmd_t                 cmd,
	input  logic signed [ELEM_W-1:0] element,
	output gme_status_t              status,
	output logic [IDX_W-1:0]         row_index,
	output logic [IDX_W-1:0]         col_index,
	output logic signed [DOT_W-1:0]  dot_value,
	output logic                     last
);

	logic [ELEM_W-1:0]        mem_q [STORE_DEPTH];
	logic [ADDR_W-1:0]        addr_a;
	logic [ADDR_W-1:0]        addr_b;
	logic [ADDR_W+1:0]        sum_a;
	logic [ADDR_W+1:0]        sum_b;
	logic signed [ELEM_W-1:0] rd_a_s1;
	logic signed [ELEM_W-1:0] rd_b_s1;
	logic                     valid_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2;
	logic                     last_s2;
	logic signed [DOT_W-1:0]  acc_q;
	logic                     done_q;

	// slot addresses of sample row and sample col at column k
	assign sum_a  = (ADDR_W+2)'(cmd.row) * (ADDR_W+2)'(cmd.dim) + (ADDR_W+2)'(cmd.k);
	assign sum_b  = (ADDR_W+2)'(cmd.col) * (ADDR_W+2)'(cmd.dim) + (ADDR_W+2)'(cmd.k);
	assign addr_a = sum_a[ADDR_W-1:0];
	assign addr_b = sum_b[ADDR_W-1:0];

	// matrix store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_addr] <= element;
		end
		rd_a_s1 <= mem_q[addr_a];
		rd_b_s1 <= mem_q[addr_b];
	end

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
	end

	// pipeline control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_issue;
			last_s1  <= cmd.rd_issue & cmd.rd_last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			done_q   <= valid_s2 & last_s2;
		end
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + DOT_W'(prod_s2);
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			row_index <= cmd.row;
			col_index <= cmd.col;
			dot_value <= acc_q;
			last      <= cmd.out_last;
		end
	end

	assign status.acc_done = done_q;

endmodule

@@ design/gme_controller.sv @@
module gme_controller
	import gme_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  gme_status_t       status,
	output gme_cmd_t          cmd
);

	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_FLUSH = 4'b0100,
		S_PUT   = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  sample_count_q;
	logic [DIM_W-1:0]  dimension_q;
	logic [ADDR_W-1:0] pos_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [K_W-1:0]    k_q;
	logic              out_valid_q;

	logic [CNT_W-1:0]  n_used;
	logic [DIM_W-1:0]  d_used;
	logic [ADDR_W+1:0] nd_prod;
	logic [ADDR_W-1:0] final_slot;
	logic [IDX_W-1:0]  n_last;
	logic [K_W-1:0]    d_last;
	logic              out_free;
	logic              entry_last;
	logic              in_acc;

	// clamp register values to the supported range
	always_comb begin
		priority if (sample_count_q == '0) begin
			n_used = CNT_W'(1);
		end else if (sample_count_q > CNT_W'(MAX_SAMPLES)) begin
			n_used = CNT_W'(MAX_SAMPLES);
		end else begin
			n_used = sample_count_q;
		end
		priority if (dimension_q == '0) begin
			d_used = DIM_W'(1);
		end else if (dimension_q > DIM_W'(MAX_DIM)) begin
			d_used = DIM_W'(MAX_DIM);
		end else begin
			d_used = dimension_q;
		end
	end

	assign nd_prod    = (ADDR_W+2)'(n_used) * (ADDR_W+2)'(d_used) - (ADDR_W+2)'(1);
	assign final_slot = nd_prod[ADDR_W-1:0];
	assign n_last     = IDX_W'(n_used - CNT_W'(1));
	assign d_last     = K_W'(d_used - DIM_W'(1));
	assign out_free   = !out_valid_q || out_ready;
	assign entry_last = (row_q == n_last) && (col_q == n_last);
	assign in_ready   = (state_q == S_LOAD);
	assign in_acc     = in_valid && in_ready;
	assign out_valid  = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= CNT_W'(MAX_SAMPLES);
			dimension_q    <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data[CNT_W-1:0];
				REG_DIMENSION:    dimension_q    <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.wr_addr  = pos_q;
		cmd.row      = row_q;
		cmd.col      = col_q;
		cmd.k        = k_q;
		cmd.dim      = d_used;
		cmd.out_last = entry_last;
		unique case (state_q)
			S_LOAD: begin
				cmd.wr_en   = in_acc;
				cmd.acc_clr = in_acc && (pos_q >= final_slot);
			end
			S_ISSUE: begin
				cmd.rd_issue = 1'b1;
				cmd.rd_last  = (k_q == d_last);
			end
			S_FLUSH: ;
			S_PUT: begin
				cmd.out_load = out_free;
				cmd.acc_clr  = out_free && !entry_last;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pos_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (pos_q >= final_slot) begin
							pos_q   <= '0;
							row_q   <= '0;
							col_q   <= '0;
							k_q     <= '0;
							state_q <= S_ISSUE;
						end else begin
							pos_q <= pos_q + ADDR_W'(1);
						end
					end
				end
				S_ISSUE: begin
					if (k_q == d_last) begin
						k_q     <= '0;
						state_q <= S_FLUSH;
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
				S_FLUSH: begin
					if (status.acc_done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						if (entry_last) begin
							state_q <= S_LOAD;
						end else begin
							if (col_q == n_last) begin
								col_q <= '0;
								row_q <= row_q + IDX_W'(1);
							end else begin
								col_q <= col_q + IDX_W'(1);
							end
							state_q <= S_ISSUE;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ design/gme_checker.sv @@
module gme_checker
	import gme_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [IDX_W-1:0]         row_index,
	input logic [IDX_W-1:0]         col_index,
	input logic signed [DOT_W-1:0]  dot_value,
	input logic                     last
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dot_value) && $stable(row_index)
			&& $stable(col_index) && $stable(last))
		else $error("output word changed while stalled");

	// no loading while a run of results is still in progress
	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input ready during a result run");

	// the final entry is on the diagonal
	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> row_index == col_index)
		else $error("last entry off the diagonal");

	// a presented output word carries known values
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({row_index, col_index, dot_value, last}))
		else $error("unknown value in output word");

endmodule

bind gram_matrix_engine gme_checker u_chk (.*);

@@ verif/gram_matrix_engine_tb.sv @@
module gram_matrix_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gme_pkg::*;

	localparam int ITEMS_TARGET  = 420;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 300;

	typedef enum bit {STEP_REG, STEP_WORD} plan_kind_t;
	typedef enum int {FILL_RANDOM, FILL_MIN, FILL_MAX, FILL_ALTERNATE, FILL_SMALL} fill_mode_t;

	typedef struct {
		plan_kind_t        kind;
		logic [CFGI_W-1:0] idx;
		logic [ELEM_W-1:0] value;
		bit                typed;
		logic [DOT_W-1:0]  dot;
	} plan_step_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [DOT_W-1:0] dot;
		logic             is_last;
	} gram_entry_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFGI_W-1:0]        cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [ELEM_W-1:0] element;
	logic                     out_valid;
	logic                     out_ready;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [DOT_W-1:0]  dot_value;
	logic                     last;

	// predictor state
	logic [CNT_W-1:0]  samples_reg;
	logic [DIM_W-1:0]  dim_reg;
	logic [ELEM_W-1:0] elem_mem [0:STORE_DEPTH-1];
	logic [ADDR_W-1:0] fill_ptr;
	gram_entry_t       gram_q [$];

	// stimulus controls
	bit               calm;
	bit               idle_on;
	bit               stall_request;
	bit               stall_served;
	bit               typed_valid;
	logic [DOT_W-1:0] typed_dot;

	// statistics
	int cycle_count;
	int items_sent;
	int reg_writes;
	int gram_loads;
	int entries_seen;
	int stall_cycles;
	int fail_count;

	gram_matrix_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.element   (element),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_index (row_index),
		.col_index (col_index),
		.dot_value (dot_value),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// sizes as the block uses them
	function automatic int eff_samples(logic [CNT_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_SAMPLES) return MAX_SAMPLES;
		return int'(v);
	endfunction

	function automatic int eff_dim(logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	// words still needed to complete the current matrix
	function automatic int words_to_finish();
		int fin;
		fin = eff_samples(samples_reg) * eff_dim(dim_reg) - 1;
		if (int'(fill_ptr) >= fin) return 1;
		return fin - int'(fill_ptr) + 1;
	endfunction

	task automatic apply_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] value);
		case (idx)
			REG_SAMPLE_COUNT: samples_reg = value[CNT_W-1:0];
			REG_DIMENSION:    dim_reg = value[DIM_W-1:0];
			default: ;
		endcase
	endtask

	// store one element word, on completion queue every gram entry, or a single typed entry
	task automatic take_element(input logic [ELEM_W-1:0] value, input bit typed,
			input logic [DOT_W-1:0] tdot);
		int n;
		int d;
		int fin;
		longint acc;
		gram_entry_t ent;
		n = eff_samples(samples_reg);
		d = eff_dim(dim_reg);
		fin = n * d - 1;
		elem_mem[fill_ptr] = value;
		if (int'(fill_ptr) < fin) begin
			fill_ptr = fill_ptr + 1'b1;
		end else begin
			fill_ptr = '0;
			gram_loads++;
			if (typed) begin
				ent.row = '0;
				ent.col = '0;
				ent.dot = tdot;
				ent.is_last = 1'b1;
				gram_q.push_back(ent);
			end else begin
				for (int i = 0; i < n; i++) begin
					for (int j = 0; j < n; j++) begin
						acc = 0;
						for (int k = 0; k < d; k++)
							acc += longint'($signed(elem_mem[i*d+k])) *
								longint'($signed(elem_mem[j*d+k]));
						ent.row = IDX_W'(i);
						ent.col = IDX_W'(j);
						ent.dot = acc[DOT_W-1:0];
						ent.is_last = (i == n - 1) && (j == n - 1);
						gram_q.push_back(ent);
					end
				end
			end
		end
	endtask

	task automatic check_entry();
		gram_entry_t want;
		entries_seen++;
		if (gram_q.size() == 0) begin
			if (fail_count < 10)
				$display("unexpected result: row %0d col %0d dot %0d last %0b",
					row_index, col_index, dot_value, last);
			fail_count++;
		end else begin
			want = gram_q.pop_front();
			if (row_index !== want.row || col_index !== want.col ||
					dot_value !== want.dot || last !== want.is_last) begin
				if (fail_count < 10)
					$display("mismatch: expected row %0d col %0d dot %0d last %0b, got row %0d col %0d dot %0d last %0b",
						want.row, want.col, $signed(want.dot), want.is_last,
						row_index, col_index, dot_value, last);
				fail_count++;
			end
		end
	endtask

	// sample both channels and the register port at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) check_entry();
			if (cfg_we) apply_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) take_element(element, typed_valid, typed_dot);
			if (in_valid && !in_ready) stall_cycles++;
		end
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d entries outstanding",
				cycle_count, gram_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random ready bursts, one long hold-off on request
	initial begin : result_sink
		int hold;
		out_ready = 1'b0;
		stall_served = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request && !stall_served) begin
				out_ready <= 1'b0;
				stall_served <= 1'b1;
				hold = HOLD_CYCLES;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				hold = $urandom_range(1, 24);
			end else begin
				out_ready <= 1'b0;
				hold = $urandom_range(1, 11);
			end
			repeat (hold - 1) @(negedge clk);
		end
	end

	function automatic plan_step_t plan_row(plan_kind_t kind, logic [CFGI_W-1:0] idx,
			logic [ELEM_W-1:0] value, bit typed, logic [DOT_W-1:0] dot);
		plan_step_t st;
		st.kind = kind;
		st.idx = idx;
		st.value = value;
		st.typed = typed;
		st.dot = dot;
		return st;
	endfunction

	function automatic fill_mode_t pick_fill();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return FILL_MIN;
			1: return FILL_MAX;
			2: return FILL_ALTERNATE;
			3, 4, 5: return FILL_SMALL;
			default: return FILL_RANDOM;
		endcase
	endfunction

	function automatic logic [ELEM_W-1:0] next_value(fill_mode_t mode);
		int v;
		v = $urandom_range(0, 1024) - 512;
		case (mode)
			FILL_MIN: return 16'h8000;
			FILL_MAX: return 16'h7fff;
			FILL_ALTERNATE: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			FILL_SMALL: return ELEM_W'(v);
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// offer one element word and hold it until accepted
	task automatic send_word(input logic [ELEM_W-1:0] value, input bit typed,
			input logic [DOT_W-1:0] dot);
		if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		element <= value;
		typed_valid <= typed;
		typed_dot <= dot;
		do @(posedge clk); while (!(in_valid && in_ready));
		items_sent++;
		@(negedge clk);
	endtask

	// register write once all results are out and the block has settled
	task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] value);
		in_valid <= 1'b0;
		while (gram_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	initial begin : stimulus
		plan_step_t plan [$];
		plan_step_t st;
		fill_mode_t mode;
		int n_val;
		int d_val;
		int loads;
		int part;
		int pick;
		int phase_no;
		int base_entries;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		element = '0;
		typed_valid = 1'b0;
		typed_dot = '0;
		calm = 1'b0;
		idle_on = 1'b1;
		stall_request = 1'b0;
		samples_reg = CNT_W'(MAX_SAMPLES);
		dim_reg = DIM_W'(MAX_DIM);
		fill_ptr = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single sample of one value: the square of each extreme, of zero and of minus one
		plan.push_back(plan_row(STEP_REG, REG_SAMPLE_COUNT, 16'd1, 1'b0, '0));
		plan.push_back(plan_row(STEP_REG, REG_DIMENSION, 16'd1, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h8000, 1'b1, 38'd1073741824));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h7fff, 1'b1, 38'd1073676289));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h0000, 1'b1, 38'd0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'hffff, 1'b1, 38'd1));
		// zero sizes act as one
		plan.push_back(plan_row(STEP_REG, REG_SAMPLE_COUNT, 16'd0, 1'b0, '0));
		plan.push_back(plan_row(STEP_REG, REG_DIMENSION, 16'd0, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h0100, 1'b1, 38'd65536));
		// upper bits of the sample count are ignored
		plan.push_back(plan_row(STEP_REG, REG_SAMPLE_COUNT, 16'h0071, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h0010, 1'b1, 38'd256));
		// two samples, mixed extremes
		plan.push_back(plan_row(STEP_REG, REG_SAMPLE_COUNT, 16'd2, 1'b0, '0));
		plan.push_back(plan_row(STEP_REG, REG_DIMENSION, 16'd1, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h7fff, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h8000, 1'b0, '0));
		// sample count above the maximum clamps to eight
		plan.push_back(plan_row(STEP_REG, REG_SAMPLE_COUNT, 16'd15, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h7fff, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h8000, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h0001, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'hffff, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h0000, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h5a5a, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'ha5a5, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h0100, 1'b0, '0));
		// shrink during a load: position already past the new end
		plan.push_back(plan_row(STEP_REG, REG_SAMPLE_COUNT, 16'd2, 1'b0, '0));
		plan.push_back(plan_row(STEP_REG, REG_DIMENSION, 16'd3, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h0064, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'hff38, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h012c, 1'b0, '0));
		plan.push_back(plan_row(STEP_REG, REG_DIMENSION, 16'd1, 1'b0, '0));
		plan.push_back(plan_row(STEP_WORD, '0, 16'h0007, 1'b0, '0));

		foreach (plan[p]) begin
			st = plan[p];
			if (st.kind == STEP_REG)
				write_reg(st.idx, st.value[CFG_W-1:0]);
			else
				send_word(st.value, st.typed, st.dot);
		end

		// random phases: a setting, then whole matrices of random content
		base_entries = entries_seen;
		phase_no = 0;
		while (items_sent < ITEMS_TARGET || entries_seen - base_entries < 48) begin
			phase_no++;
			calm = (items_sent >= ITEMS_TARGET * 85 / 100);
			idle_on = ($urandom_range(0, 3) != 0);
			mode = pick_fill();
			loads = $urandom_range(1, 3);
			case (phase_no)
				1: begin
					n_val = MAX_SAMPLES;
					d_val = 2;
				end
				2: begin
					n_val = 1;
					d_val = MAX_DIM;
					mode = FILL_MIN;
				end
				3: begin
					// receiver holds off so that loading of the following matrices stalls
					n_val = 2;
					d_val = 2;
					loads = 6;
				end
				default: begin
					pick = $urandom_range(0, 19);
					if (pick == 0) begin
						n_val = $urandom_range(MAX_SAMPLES, 15);
						d_val = $urandom_range(1, 4);
					end else if (pick == 1) begin
						n_val = $urandom_range(1, 2);
						d_val = $urandom_range(MAX_DIM, 127);
					end else if (pick == 2) begin
						n_val = $urandom_range(0, 3);
						d_val = 0;
					end else if (pick == 3) begin
						n_val = 0;
						d_val = $urandom_range(1, 8);
					end else begin
						n_val = $urandom_range(1, 4);
						d_val = $urandom_range(1, 8);
					end
					if ($urandom_range(0, 4) == 0)
						n_val += 16 * $urandom_range(1, 7);
				end
			endcase
			write_reg(REG_SAMPLE_COUNT, CFG_W'(n_val));
			write_reg(REG_DIMENSION, CFG_W'(d_val));
			// long hold-off starts right as the loads begin
			if (phase_no == 3) begin
				stall_request <= 1'b1;
				wait (stall_served);
			end
			repeat (loads) begin
				if (items_sent < ITEMS_TARGET || entries_seen - base_entries < 48) begin
					// now and then resize in the middle of a load
					if ($urandom_range(0, 9) == 0) begin
						part = $urandom_range(0, words_to_finish() - 1);
						repeat (part) send_word(next_value(mode), 1'b0, '0);
						if ($urandom_range(0, 1) != 0)
							write_reg(REG_SAMPLE_COUNT, CFG_W'($urandom_range(1, 4)));
						else
							write_reg(REG_DIMENSION, CFG_W'($urandom_range(1, 8)));
					end
					repeat (words_to_finish()) send_word(next_value(mode), 1'b0, '0);
				end
			end
		end

		// drain and let the block settle
		in_valid <= 1'b0;
		while (gram_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run: %0d element words, %0d register writes, %0d gram matrices, %0d entries",
			items_sent, reg_writes, gram_loads, entries_seen);
		$display("sizes from 1x1 up to 8 samples and 64 values, %0d input stall cycles, %0d failures",
			stall_cycles, fail_count);
		if (fail_count == 0 && gram_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
design/gme_pkg.sv
design/gme_datapath.sv
design/gme_controller.sv
design/gram_matrix_engine.sv
design/gme_checker.sv
verif/gram_matrix_engine_tb.sv
